### rtl/line_follow_drive_controller_macros.svh
// Assertion macros shared by the drive controller RTL.
`ifndef LINE_FOLLOW_DRIVE_CONTROLLER_MACROS_SVH
`define LINE_FOLLOW_DRIVE_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lfdc_pkg.sv
// Shared types and constants for the line follow drive controller.
`default_nettype none
package lfdc_pkg;

    // Item kinds on the input channel.
    typedef enum logic [1:0] {
        OP_CMD   = 2'd0,
        OP_SENSE = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_MAX_SPEED  = 3'd0,
        CFG_LINE_SPEED = 3'd1,
        CFG_GAIN_P     = 3'd2,
        CFG_GAIN_D     = 3'd3,
        CFG_TIMEOUT_MS = 3'd4
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned ERR_W     = 4;

    // Command characters.
    localparam logic [7:0] CH_TRACK_ON_X  = 8'h58; // X
    localparam logic [7:0] CH_TRACK_ON_W  = 8'h57; // W
    localparam logic [7:0] CH_TRACK_OFF_X = 8'h78; // x
    localparam logic [7:0] CH_TRACK_OFF_W = 8'h77; // w
    localparam logic [7:0] CH_FWD         = 8'h46; // F
    localparam logic [7:0] CH_BACK        = 8'h42; // B
    localparam logic [7:0] CH_LEFT        = 8'h4C; // L
    localparam logic [7:0] CH_RIGHT       = 8'h52; // R
    localparam logic [7:0] CH_FWD_LEFT    = 8'h47; // G
    localparam logic [7:0] CH_FWD_RIGHT   = 8'h49; // I
    localparam logic [7:0] CH_BACK_LEFT   = 8'h4A; // J
    localparam logic [7:0] CH_BACK_RIGHT  = 8'h48; // H
    localparam logic [7:0] CH_STOP        = 8'h53; // S

    // Outcome of a manual command decode.
    typedef struct packed {
        logic hit;
        logic stop;
    } t_man_ctl;

endpackage
`default_nettype wire

### rtl/lfdc_manual.sv
// Manual command decoder: maps a letter to a signed wheel speed pair.
`default_nettype none
module lfdc_manual #(
    parameter int unsigned DUTY_BITS = 10
) (
    input  wire logic [7:0]              i_rx_byte,
    input  wire logic [DUTY_BITS-1:0]    i_max_speed,
    output lfdc_pkg::t_man_ctl           o_ctl,
    output logic signed [DUTY_BITS+4:0]  o_left,
    output logic signed [DUTY_BITS+4:0]  o_right
);
    import lfdc_pkg::*;

    localparam int unsigned SPD_W = DUTY_BITS + 5;

    logic signed [SPD_W-1:0] full;
    logic signed [SPD_W-1:0] half;

    assign full = $signed({{(SPD_W-DUTY_BITS){1'b0}}, i_max_speed});
    assign half = $signed({{(SPD_W-DUTY_BITS+1){1'b0}}, i_max_speed[DUTY_BITS-1:1]});

    always_comb begin
        o_ctl   = '{hit: 1'b1, stop: 1'b0};
        o_left  = '0;
        o_right = '0;
        unique case (i_rx_byte)
            CH_FWD: begin
                o_left  = full;
                o_right = full;
            end
            CH_BACK: begin
                o_left  = -full;
                o_right = -full;
            end
            CH_LEFT: begin
                o_left  = -full;
                o_right = full;
            end
            CH_RIGHT: begin
                o_left  = full;
                o_right = -full;
            end
            CH_FWD_LEFT: begin
                o_left  = half;
                o_right = full;
            end
            CH_FWD_RIGHT: begin
                o_left  = full;
                o_right = half;
            end
            CH_BACK_LEFT: begin
                o_left  = -half;
                o_right = -full;
            end
            CH_BACK_RIGHT: begin
                o_left  = -full;
                o_right = -half;
            end
            CH_STOP: begin
                o_ctl.stop = 1'b1;
            end
            default: begin
                o_ctl.hit = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/lfdc_pd.sv
// Line position error and PD correction for tracking mode.
`default_nettype none
module lfdc_pd #(
    parameter int unsigned DUTY_BITS = 10
) (
    input  wire logic                         i_sense_left,
    input  wire logic                         i_sense_center,
    input  wire logic                         i_sense_right,
    input  wire logic signed [lfdc_pkg::ERR_W-1:0] i_prev_error,
    input  wire logic [DUTY_BITS-1:0]         i_line_speed,
    input  wire logic [DUTY_BITS-1:0]         i_gain_p,
    input  wire logic [DUTY_BITS-1:0]         i_gain_d,
    output logic signed [lfdc_pkg::ERR_W-1:0] o_error,
    output logic signed [DUTY_BITS+4:0]       o_left,
    output logic signed [DUTY_BITS+4:0]       o_right
);
    import lfdc_pkg::*;

    localparam int unsigned SPD_W = DUTY_BITS + 5;

    // Sensor patterns, left-center-right.
    localparam logic [2:0] PAT_LOST      = 3'b000;
    localparam logic [2:0] PAT_RIGHT     = 3'b001;
    localparam logic [2:0] PAT_CENTER    = 3'b010;
    localparam logic [2:0] PAT_CTR_RIGHT = 3'b011;
    localparam logic [2:0] PAT_LEFT      = 3'b100;
    localparam logic [2:0] PAT_CTR_LEFT  = 3'b110;

    logic [2:0]              pattern;
    logic signed [ERR_W:0]   diff;
    logic signed [SPD_W-1:0] err_x;
    logic signed [SPD_W-1:0] diff_x;
    logic signed [SPD_W-1:0] p_term;
    logic signed [SPD_W-1:0] d_term;
    logic signed [SPD_W-1:0] corr;
    logic signed [SPD_W-1:0] base;

    assign pattern = {i_sense_left, i_sense_center, i_sense_right};

    always_comb begin
        case (pattern)
            PAT_CENTER:    o_error = 4'sd0;
            PAT_CTR_RIGHT: o_error = 4'sd1;
            PAT_RIGHT:     o_error = 4'sd2;
            PAT_CTR_LEFT:  o_error = -4'sd1;
            PAT_LEFT:      o_error = -4'sd2;
            PAT_LOST: begin
                // Line lost: push hard toward the side the line was last seen.
                if (i_prev_error < 0) begin
                    o_error = -4'sd4;
                end else if (i_prev_error > 0) begin
                    o_error = 4'sd4;
                end else begin
                    o_error = 4'sd0;
                end
            end
            default:       o_error = 4'sd0;
        endcase
    end

    assign diff   = {o_error[ERR_W-1], o_error} - {i_prev_error[ERR_W-1], i_prev_error};
    assign err_x  = {{(SPD_W-ERR_W){o_error[ERR_W-1]}}, o_error};
    assign diff_x = {{(SPD_W-ERR_W-1){diff[ERR_W]}}, diff};

    // The error factors are at most five bits, so these are small shift-add products.
    assign p_term = $signed({{(SPD_W-DUTY_BITS){1'b0}}, i_gain_p}) * err_x;
    assign d_term = $signed({{(SPD_W-DUTY_BITS){1'b0}}, i_gain_d}) * diff_x;
    assign corr   = p_term + d_term;
    assign base   = $signed({{(SPD_W-DUTY_BITS){1'b0}}, i_line_speed});

    assign o_left  = base + corr;
    assign o_right = base - corr;

endmodule
`default_nettype wire

### rtl/lfdc_wheel.sv
// One wheel output stage: direction bits and a clamped duty from a signed speed.
`default_nettype none
module lfdc_wheel #(
    parameter int unsigned DUTY_BITS = 10
) (
    input  wire logic signed [DUTY_BITS+4:0] i_speed,
    input  wire logic [DUTY_BITS-1:0]        i_limit,
    output logic [1:0]                       o_dir,
    output logic [DUTY_BITS-1:0]             o_duty
);
    localparam int unsigned SPD_W = DUTY_BITS + 5;

    logic [SPD_W-1:0] mag;

    assign mag = i_speed[SPD_W-1] ? SPD_W'(-i_speed) : SPD_W'(i_speed);

    // Bit 0 forward, bit 1 reverse; zero speed counts as forward.
    assign o_dir = i_speed[SPD_W-1] ? 2'b10 : 2'b01;

    always_comb begin
        if (mag > {{(SPD_W-DUTY_BITS){1'b0}}, i_limit}) begin
            o_duty = i_limit;
        end else begin
            o_duty = mag[DUTY_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

### rtl/line_follow_drive_controller.sv
// Top level of the line follow drive controller: registers, mode control and handshakes.
`default_nettype none
// Two-wheel drive controller with a manual command mode and a PD line-tracking mode.
// Each input beat is a command byte (operation 0), a line sensor sample (operation 1)
// or a millisecond tick (operation 2); every beat yields exactly one output beat that
// reports the drive state after the beat: direction bits, both wheel duties, the
// tracking flag and the last line error. Operation 3 changes nothing and only reports.
// The block accepts one input beat per clock cycle unless a stalled output holds it back. A
// beat is captured in an input register; when the state register can advance, one pass
// through the decode and PD logic updates the state registers, which also serve as the
// output register, and output valid rises as they load. The input register and the state
// register together form a two-entry path, so a new beat is taken while a finished one
// waits on a stalled output. Configuration registers are written through a separate port
// that is always ready; write them only while no beat is in flight.
module line_follow_drive_controller #(
    parameter int unsigned DUTY_BITS = 10,
    parameter int unsigned IDLE_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [1:0]               i_operation,
    input  wire logic [7:0]               i_rx_byte,
    input  wire logic                     i_sense_left,
    input  wire logic                     i_sense_center,
    input  wire logic                     i_sense_right,

    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [3:0]                    o_dir_bits,
    output logic [DUTY_BITS-1:0]          o_left_duty,
    output logic [DUTY_BITS-1:0]          o_right_duty,
    output logic                          o_tracking_on,
    output logic signed [lfdc_pkg::ERR_W-1:0] o_line_error,

    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [lfdc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [((DUTY_BITS > lfdc_pkg::TIMEOUT_W) ? DUTY_BITS
                        : lfdc_pkg::TIMEOUT_W)-1:0] i_cfg_data
);
    import lfdc_pkg::*;

    `include "line_follow_drive_controller_macros.svh"

    localparam int unsigned SPD_W = DUTY_BITS + 5;
    // Width used to compare the idle count with the timeout.
    localparam int unsigned CMP_W = (IDLE_BITS > TIMEOUT_W) ? IDLE_BITS : TIMEOUT_W;

    // Configuration registers.
    logic [DUTY_BITS-1:0] r_max_speed;
    logic [DUTY_BITS-1:0] r_line_speed;
    logic [DUTY_BITS-1:0] r_gain_p;
    logic [DUTY_BITS-1:0] r_gain_d;
    logic [TIMEOUT_W-1:0] r_timeout_ms;

    // Input register.
    logic       r_in_valid;
    logic [1:0] r_op;
    logic [7:0] r_rx_byte;
    logic       r_sense_left;
    logic       r_sense_center;
    logic       r_sense_right;

    // State, which doubles as the output register.
    logic                    r_out_valid;
    logic                    r_track;
    logic signed [ERR_W-1:0] r_prev;
    logic [IDLE_BITS-1:0]    r_idle;
    logic [3:0]              r_dirs;
    logic [DUTY_BITS-1:0]    r_duty_left;
    logic [DUTY_BITS-1:0]    r_duty_right;

    logic                    n_track;
    logic signed [ERR_W-1:0] n_prev;
    logic [IDLE_BITS-1:0]    n_idle;
    logic [3:0]              n_dirs;
    logic [DUTY_BITS-1:0]    n_duty_left;
    logic [DUTY_BITS-1:0]    n_duty_right;

    logic                    adv;
    logic                    in_load;
    logic                    out_take;

    t_man_ctl                man_ctl;
    logic signed [SPD_W-1:0] man_left;
    logic signed [SPD_W-1:0] man_right;
    logic signed [ERR_W-1:0] pd_error;
    logic signed [SPD_W-1:0] pd_left;
    logic signed [SPD_W-1:0] pd_right;

    logic                    sel_track;
    logic signed [SPD_W-1:0] whl_left_speed;
    logic signed [SPD_W-1:0] whl_right_speed;
    logic [DUTY_BITS-1:0]    whl_limit;
    logic [1:0]              whl_left_dir;
    logic [1:0]              whl_right_dir;
    logic [DUTY_BITS-1:0]    whl_left_duty;
    logic [DUTY_BITS-1:0]    whl_right_duty;

    // ------------------------------------------------------------------
    // Handshakes. The state register advances when it is empty or its
    // beat is being taken; the input register refills whenever it drains.
    // ------------------------------------------------------------------
    assign out_take    = r_out_valid && !i_out_stall;
    assign adv         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !adv;
    assign in_load     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_op           <= i_operation;
            r_rx_byte      <= i_rx_byte;
            r_sense_left   <= i_sense_left;
            r_sense_center <= i_sense_center;
            r_sense_right  <= i_sense_right;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers. Speeds and gains keep their low duty bits.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed  <= DUTY_BITS'(1004);
            r_line_speed <= DUTY_BITS'(666);
            r_gain_p     <= DUTY_BITS'(154);
            r_gain_d     <= DUTY_BITS'(717);
            r_timeout_ms <= TIMEOUT_W'(500);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_SPEED:  r_max_speed  <= i_cfg_data[DUTY_BITS-1:0];
                CFG_LINE_SPEED: r_line_speed <= i_cfg_data[DUTY_BITS-1:0];
                CFG_GAIN_P:     r_gain_p     <= i_cfg_data[DUTY_BITS-1:0];
                CFG_GAIN_D:     r_gain_d     <= i_cfg_data[DUTY_BITS-1:0];
                CFG_TIMEOUT_MS: r_timeout_ms <= i_cfg_data[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath. Manual letters and PD tracking share one pair of wheel
    // stages; a sensor beat selects the PD speeds and the line clamp.
    // ------------------------------------------------------------------
    lfdc_manual #(
        .DUTY_BITS (DUTY_BITS)
    ) u_manual (
        .i_rx_byte   (r_rx_byte),
        .i_max_speed (r_max_speed),
        .o_ctl       (man_ctl),
        .o_left      (man_left),
        .o_right     (man_right)
    );

    lfdc_pd #(
        .DUTY_BITS (DUTY_BITS)
    ) u_pd (
        .i_sense_left   (r_sense_left),
        .i_sense_center (r_sense_center),
        .i_sense_right  (r_sense_right),
        .i_prev_error   (r_prev),
        .i_line_speed   (r_line_speed),
        .i_gain_p       (r_gain_p),
        .i_gain_d       (r_gain_d),
        .o_error        (pd_error),
        .o_left         (pd_left),
        .o_right        (pd_right)
    );

    assign sel_track       = (r_op == OP_SENSE);
    assign whl_left_speed  = sel_track ? pd_left  : man_left;
    assign whl_right_speed = sel_track ? pd_right : man_right;
    assign whl_limit       = sel_track ? r_line_speed : r_max_speed;

    lfdc_wheel #(
        .DUTY_BITS (DUTY_BITS)
    ) u_wheel_left (
        .i_speed (whl_left_speed),
        .i_limit (whl_limit),
        .o_dir   (whl_left_dir),
        .o_duty  (whl_left_duty)
    );

    lfdc_wheel #(
        .DUTY_BITS (DUTY_BITS)
    ) u_wheel_right (
        .i_speed (whl_right_speed),
        .i_limit (whl_limit),
        .o_dir   (whl_right_dir),
        .o_duty  (whl_right_duty)
    );

    // ------------------------------------------------------------------
    // Next state for one beat. Any mode switch halts the car; entering
    // tracking also clears the last error. In manual mode the failsafe
    // halts the car whenever the idle count is past the timeout.
    // ------------------------------------------------------------------
    always_comb begin
        n_track      = r_track;
        n_prev       = r_prev;
        n_idle       = r_idle;
        n_dirs       = r_dirs;
        n_duty_left  = r_duty_left;
        n_duty_right = r_duty_right;

        unique case (r_op)
            OP_CMD: begin
                n_idle = '0;
                if (r_rx_byte == CH_TRACK_ON_X || r_rx_byte == CH_TRACK_ON_W) begin
                    n_track      = 1'b1;
                    n_prev       = '0;
                    n_dirs       = '0;
                    n_duty_left  = '0;
                    n_duty_right = '0;
                end else if (r_rx_byte == CH_TRACK_OFF_X || r_rx_byte == CH_TRACK_OFF_W) begin
                    n_track      = 1'b0;
                    n_dirs       = '0;
                    n_duty_left  = '0;
                    n_duty_right = '0;
                end else if (!r_track && man_ctl.hit) begin
                    if (man_ctl.stop) begin
                        n_dirs       = '0;
                        n_duty_left  = '0;
                        n_duty_right = '0;
                    end else begin
                        n_dirs       = {whl_right_dir, whl_left_dir};
                        n_duty_left  = whl_left_duty;
                        n_duty_right = whl_right_duty;
                    end
                end
            end
            OP_SENSE: begin
                if (r_track) begin
                    n_prev       = pd_error;
                    n_dirs       = {whl_right_dir, whl_left_dir};
                    n_duty_left  = whl_left_duty;
                    n_duty_right = whl_right_duty;
                end
            end
            OP_TICK: begin
                if (!(&r_idle)) begin
                    n_idle = r_idle + IDLE_BITS'(1);
                end
            end
            default: begin
            end
        endcase

        if (!n_track && (CMP_W'(n_idle) > CMP_W'(r_timeout_ms))) begin
            n_dirs       = '0;
            n_duty_left  = '0;
            n_duty_right = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_track      <= 1'b0;
            r_prev       <= '0;
            r_idle       <= '0;
            r_dirs       <= '0;
            r_duty_left  <= '0;
            r_duty_right <= '0;
        end else begin
            if (adv) begin
                r_out_valid  <= 1'b1;
                r_track      <= n_track;
                r_prev       <= n_prev;
                r_idle       <= n_idle;
                r_dirs       <= n_dirs;
                r_duty_left  <= n_duty_left;
                r_duty_right <= n_duty_right;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_dir_bits    = r_dirs;
    assign o_left_duty   = r_duty_left;
    assign o_right_duty  = r_duty_right;
    assign o_tracking_on = r_track;
    assign o_line_error  = r_prev;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `LFDC_ASSERT_NOW(a_halt_zero_duty, i_clk, i_rst_n,
        r_dirs == 4'b0000, r_duty_left == '0 && r_duty_right == '0,
        "halted car has a nonzero duty")

    `LFDC_ASSERT_NOW(a_dir_pairs, i_clk, i_rst_n,
        r_dirs != 4'b0000, $onehot(r_dirs[1:0]) && $onehot(r_dirs[3:2]),
        "wheel direction bits are not one per wheel")

    `LFDC_ASSERT_NXT(a_enter_tracking, i_clk, i_rst_n,
        adv && r_op == OP_CMD && (r_rx_byte == CH_TRACK_ON_X || r_rx_byte == CH_TRACK_ON_W),
        r_track && r_prev == '0 && r_dirs == 4'b0000 && r_idle == '0,
        "entering tracking did not stop the car and clear the error")

endmodule
`default_nettype wire

### verif/line_follow_drive_checker.sv
// Checker for the drive controller: predicts each result beat and compares it with the DUT.
module line_follow_drive_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_sense_left,
    input  logic              i_sense_center,
    input  logic              i_sense_right,

    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [3:0]        i_dir_bits,
    input  logic [9:0]        i_left_duty,
    input  logic [9:0]        i_right_duty,
    input  logic              i_tracking_on,
    input  logic signed [3:0] i_line_error,

    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,

    output int                o_fail_count,
    output int                o_outstanding
);
    import lfdc_pkg::*;

    localparam logic [9:0]  RST_MAX_SPEED  = 10'd1004;
    localparam logic [9:0]  RST_LINE_SPEED = 10'd666;
    localparam logic [9:0]  RST_GAIN_P     = 10'd154;
    localparam logic [9:0]  RST_GAIN_D     = 10'd717;
    localparam logic [15:0] RST_TIMEOUT_MS = 16'd500;
    localparam logic [15:0] IDLE_SAT       = 16'hFFFF;

    localparam logic [3:0] DIR_L_FWD = 4'b0001;
    localparam logic [3:0] DIR_L_REV = 4'b0010;
    localparam logic [3:0] DIR_R_FWD = 4'b0100;
    localparam logic [3:0] DIR_R_REV = 4'b1000;

    // Sensor patterns as {left, center, right}.
    localparam logic [2:0] PAT_NONE         = 3'b000;
    localparam logic [2:0] PAT_RIGHT        = 3'b001;
    localparam logic [2:0] PAT_CENTER       = 3'b010;
    localparam logic [2:0] PAT_CENTER_RIGHT = 3'b011;
    localparam logic [2:0] PAT_LEFT         = 3'b100;
    localparam logic [2:0] PAT_LEFT_CENTER  = 3'b110;
    localparam int         LOST_ERR         = 4;

    typedef struct packed {
        logic [3:0]        dirs;
        logic [9:0]        left;
        logic [9:0]        right;
        logic              trk;
        logic signed [3:0] err;
    } t_drive_report;

    logic [9:0]  max_spd, line_spd, kp, kd;
    logic [15:0] tmo;
    logic        trk;
    int          last_err;
    logic [15:0] idle_ms;
    logic [3:0]  dirs;
    logic [9:0]  duty_l, duty_r;

    t_drive_report pending_reports[$];
    int            n_bad = 0;
    int            n_seen = 0;

    assign o_fail_count = n_bad;

    function automatic void stop_wheels();
        dirs   = '0;
        duty_l = '0;
        duty_r = '0;
    endfunction

    function automatic void set_wheels(int left, int right, int limit);
        int mag_l, mag_r;
        mag_l = (left < 0) ? -left : left;
        mag_r = (right < 0) ? -right : right;
        if (mag_l > limit) mag_l = limit;
        if (mag_r > limit) mag_r = limit;
        dirs   = ((left >= 0) ? DIR_L_FWD : DIR_L_REV) | ((right >= 0) ? DIR_R_FWD : DIR_R_REV);
        duty_l = 10'(mag_l);
        duty_r = 10'(mag_r);
    endfunction

    function automatic void follow_line(logic [2:0] pat);
        int err, corr;
        case (pat)
            PAT_CENTER:       err = 0;
            PAT_CENTER_RIGHT: err = 1;
            PAT_RIGHT:        err = 2;
            PAT_LEFT_CENTER:  err = -1;
            PAT_LEFT:         err = -2;
            // A lost line keeps pushing toward the side it was last seen on.
            PAT_NONE:         err = (last_err < 0) ? -LOST_ERR : ((last_err > 0) ? LOST_ERR : 0);
            default:          err = 0;
        endcase
        corr = int'(kp) * err + int'(kd) * (err - last_err);
        last_err = err;
        set_wheels(int'(line_spd) + corr, int'(line_spd) - corr, int'(line_spd));
    endfunction

    function automatic t_drive_report apply_beat(logic [1:0] op, logic [7:0] ch,
                                                 logic [2:0] pat);
        int            full, half;
        t_drive_report rep;
        full = int'(max_spd);
        half = int'(max_spd >> 1);
        case (op)
            OP_CMD: begin
                idle_ms = '0;
                if (ch == CH_TRACK_ON_X || ch == CH_TRACK_ON_W) begin
                    trk      = 1'b1;
                    last_err = 0;
                    stop_wheels();
                end else if (ch == CH_TRACK_OFF_X || ch == CH_TRACK_OFF_W) begin
                    trk = 1'b0;
                    stop_wheels();
                end
                if (!trk) begin
                    case (ch)
                        CH_FWD:        set_wheels(full, full, full);
                        CH_BACK:       set_wheels(-full, -full, full);
                        CH_LEFT:       set_wheels(-full, full, full);
                        CH_RIGHT:      set_wheels(full, -full, full);
                        CH_FWD_LEFT:   set_wheels(half, full, full);
                        CH_FWD_RIGHT:  set_wheels(full, half, full);
                        CH_BACK_LEFT:  set_wheels(-half, -full, full);
                        CH_BACK_RIGHT: set_wheels(-full, -half, full);
                        CH_STOP:       stop_wheels();
                        default:       ;
                    endcase
                end
            end
            OP_SENSE: if (trk) follow_line(pat);
            OP_TICK:  if (idle_ms != IDLE_SAT) idle_ms = idle_ms + 16'd1;
            default:  ;
        endcase
        // The failsafe is checked after every beat, whatever its kind.
        if (!trk && idle_ms > tmo) stop_wheels();
        rep.dirs  = dirs;
        rep.left  = duty_l;
        rep.right = duty_r;
        rep.trk   = trk;
        rep.err   = 4'(last_err);
        return rep;
    endfunction

    always @(posedge i_clk) begin : watch
        t_drive_report want, got;
        if (!i_rst_n) begin
            max_spd  = RST_MAX_SPEED;
            line_spd = RST_LINE_SPEED;
            kp       = RST_GAIN_P;
            kd       = RST_GAIN_D;
            tmo      = RST_TIMEOUT_MS;
            trk      = 1'b0;
            last_err = 0;
            idle_ms  = '0;
            stop_wheels();
            pending_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MAX_SPEED:  max_spd  = i_cfg_data[9:0];
                    CFG_LINE_SPEED: line_spd = i_cfg_data[9:0];
                    CFG_GAIN_P:     kp       = i_cfg_data[9:0];
                    CFG_GAIN_D:     kd       = i_cfg_data[9:0];
                    CFG_TIMEOUT_MS: tmo      = i_cfg_data;
                    default:        ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.dirs  = i_dir_bits;
                got.left  = i_left_duty;
                got.right = i_right_duty;
                got.trk   = i_tracking_on;
                got.err   = i_line_error;
                n_seen++;
                if (pending_reports.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("result beat %0d arrived with nothing expected", n_seen);
                end else begin
                    want = pending_reports.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("result beat %0d: expected dir %h left %0d right %0d %s",
                                     n_seen, want.dirs, want.left, want.right, "");
                            $display("    expected trk %0b err %0d", want.trk, want.err);
                            $display("    got dir %h left %0d right %0d trk %0b err %0d",
                                     got.dirs, got.left, got.right, got.trk, got.err);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_reports.push_back(apply_beat(i_operation, i_rx_byte,
                    {i_sense_left, i_sense_center, i_sense_right}));
        end
        o_outstanding <= pending_reports.size();
    end

endmodule

### verif/tb_line_follow_drive_controller.sv
// Testbench top for the drive controller: clock, reset, stimulus, stalls and the verdict.
module tb_line_follow_drive_controller;
    import lfdc_pkg::*;

    // The package names only the three real item kinds; the fourth code must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;

    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_operation = '0;
    logic [7:0]        i_rx_byte = '0;
    logic              i_sense_left = 1'b0;
    logic              i_sense_center = 1'b0;
    logic              i_sense_right = 1'b0;

    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [3:0]        o_dir_bits;
    logic [9:0]        o_left_duty;
    logic [9:0]        o_right_duty;
    logic              o_tracking_on;
    logic signed [3:0] o_line_error;

    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index = '0;
    logic [15:0]       i_cfg_data = '0;

    // Idle and stall odds in percent per cycle, changed from phase to phase.
    int   snd_idle_pct = 0;
    int   rcv_stall_pct = 0;

    // One long receiver hold-off, requested by the stimulus and timed by the receiver.
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    int   fail_count;
    int   outstanding;

    line_follow_drive_controller dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_rx_byte      (i_rx_byte),
        .i_sense_left   (i_sense_left),
        .i_sense_center (i_sense_center),
        .i_sense_right  (i_sense_right),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_dir_bits     (o_dir_bits),
        .o_left_duty    (o_left_duty),
        .o_right_duty   (o_right_duty),
        .o_tracking_on  (o_tracking_on),
        .o_line_error   (o_line_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    line_follow_drive_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_rx_byte      (i_rx_byte),
        .i_sense_left   (i_sense_left),
        .i_sense_center (i_sense_center),
        .i_sense_right  (i_sense_right),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_dir_bits     (o_dir_bits),
        .i_left_duty    (o_left_duty),
        .i_right_duty   (o_right_duty),
        .i_tracking_on  (o_tracking_on),
        .i_line_error   (o_line_error),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver side. Stall is redrawn every cycle from the phase odds, except during the
    // single long hold-off, which keeps the output stalled long enough for the block to
    // fill both of its entries and push back on the sender.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= 150;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
        end
    end

    // Offer one input beat and return at the edge where it is taken. A gap, if one is
    // drawn, drops valid first; otherwise valid stays high straight into the next beat so
    // it is never lowered and raised in the same step. Stall is read right after the edge,
    // before the block updates it, so the value seen is the one the edge acted on.
    task automatic send_beat(input logic [1:0] op, input logic [7:0] ch,
                             input logic [2:0] pat);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < snd_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_operation    <= op;
        i_rx_byte      <= ch;
        i_sense_left   <= pat[2];
        i_sense_center <= pat[1];
        i_sense_right  <= pat[0];
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Fields that an item kind does not use still carry random values.
    task automatic send_cmd(input logic [7:0] ch);
        send_beat(OP_CMD, ch, 3'($urandom));
    endtask

    task automatic send_sense(input logic [2:0] pat);
        send_beat(OP_SENSE, 8'($urandom), pat);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_beat(OP_TICK, 8'($urandom), 3'($urandom));
    endtask

    // Stop offering beats and wait until every expected result has been taken. The first
    // edge lets the checker count a beat accepted at the current edge.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Registers change only with nothing in flight, so every beat of a phase sees one
    // consistent setting. Valid stays high across the five writes and drops once at the end.
    task automatic set_config(input logic [9:0] max_spd, input logic [9:0] line_spd,
                              input logic [9:0] kp, input logic [9:0] kd,
                              input logic [15:0] tmo);
        wait_drained();
        write_reg(CFG_MAX_SPEED, 16'(max_spd));
        write_reg(CFG_LINE_SPEED, 16'(line_spd));
        write_reg(CFG_GAIN_P, 16'(kp));
        write_reg(CFG_GAIN_D, 16'(kd));
        write_reg(CFG_TIMEOUT_MS, tmo);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int snd, input int rcv);
        snd_idle_pct = snd;
        rcv_stall_pct <= rcv;
    endtask

    function automatic logic [7:0] mode_key(input int unsigned k);
        case (k)
            0:       return CH_TRACK_ON_X;
            1:       return CH_TRACK_ON_W;
            2:       return CH_TRACK_OFF_X;
            default: return CH_TRACK_OFF_W;
        endcase
    endfunction

    function automatic logic [7:0] manual_key(input int unsigned k);
        case (k)
            0:       return CH_FWD;
            1:       return CH_BACK;
            2:       return CH_LEFT;
            3:       return CH_RIGHT;
            4:       return CH_FWD_LEFT;
            5:       return CH_FWD_RIGHT;
            6:       return CH_BACK_LEFT;
            7:       return CH_BACK_RIGHT;
            default: return CH_STOP;
        endcase
    endfunction

    // Random traffic. Mode letters come often enough that the car keeps moving between
    // manual driving and line tracking, so sensor beats mostly land in tracking stretches
    // and drive the PD path; stray bytes, the unused item kind and tick bursts make up
    // the rest, and the bursts trip the failsafe when the timeout is short.
    task automatic random_beats(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_cmd(mode_key($urandom_range(0, 3)));
            else if (pick < 28)
                send_cmd(manual_key($urandom_range(0, 8)));
            else if (pick < 33)
                send_cmd(8'($urandom));
            else if (pick < 68)
                send_sense(3'($urandom));
            else if (pick < 95)
                send_ticks($urandom_range(1, 3));
            else
                send_beat(OP_UNUSED, 8'($urandom), 3'($urandom));
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset setting: every manual letter, the byte extremes,
        // a sensor beat and the unused kind in manual mode, then tracking.
        send_cmd(CH_FWD);
        send_cmd(CH_BACK);
        send_cmd(CH_LEFT);
        send_cmd(CH_RIGHT);
        send_cmd(CH_FWD_LEFT);
        send_cmd(CH_FWD_RIGHT);
        send_cmd(CH_BACK_LEFT);
        send_cmd(CH_BACK_RIGHT);
        send_cmd(CH_STOP);
        send_cmd(8'h00);
        send_cmd(8'hFF);
        send_sense(3'b111);
        send_beat(OP_UNUSED, 8'hFF, 3'b111);
        // In tracking the manual letters do nothing. A lost line follows the sign of the
        // last error: positive, then negative, then zero after the left-and-right pattern.
        send_cmd(CH_TRACK_ON_X);
        send_cmd(CH_FWD);
        send_sense(3'b011);
        send_sense(3'b000);
        send_sense(3'b100);
        send_sense(3'b000);
        send_sense(3'b101);
        send_sense(3'b000);
        send_sense(3'b001);
        send_sense(3'b110);
        send_sense(3'b010);
        send_sense(3'b111);
        send_ticks(1);
        send_cmd(CH_TRACK_OFF_X);
        send_cmd(CH_TRACK_ON_W);
        send_cmd(CH_TRACK_OFF_W);

        // Failsafe edge at the reset timeout: the car still runs after exactly that many
        // idle ticks and stops on the next one; later non-command beats keep it stopped.
        send_cmd(CH_FWD);
        send_ticks(500);
        send_ticks(1);
        send_beat(OP_UNUSED, 8'h00, 3'b000);
        send_sense(3'b010);

        // No idling, with the long receiver hold-off early on.
        set_idling(0, 0);
        hold_req <= 1'b1;
        random_beats(300);

        // Every register at its top. With the largest timeout a short run of ticks
        // leaves the car running.
        set_config(10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF);
        send_cmd(CH_TRACK_OFF_W);
        send_cmd(CH_FWD);
        send_ticks(40);
        set_idling(82, 0);
        random_beats(300);

        // Every register at zero: the first idle tick in manual mode stops the car.
        set_config(10'd0, 10'd0, 10'd0, 10'd0, 16'd0);
        set_idling(0, 82);
        random_beats(300);

        // A random setting with a short timeout so tick bursts reach the failsafe.
        set_config(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                   16'($urandom_range(0, 40)));
        set_idling(37, 37);
        random_beats(300);

        // Drain, let the pipeline settle, then decide.
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS line_follow_drive_controller");
        end else begin
            $display("FAIL line_follow_drive_controller");
        end
        $finish;
    end

    // Guard against a hung handshake; the slowest legal run is far shorter than this.
    initial begin : watchdog
        #2000000;
        $display("FAIL line_follow_drive_controller");
        $finish;
    end

endmodule
